@@ rtl/at_reply_line_framer_macros.svh @@
// Assertion macros shared by the framer RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef AT_REPLY_LINE_FRAMER_MACROS_SVH
`define AT_REPLY_LINE_FRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ARF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ARF_ASSERT_IMP(label, ante, cons)
`define ARF_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/arf_pkg.sv @@
package arf_pkg;

  // Parser phase of the current line.
  typedef enum logic [3:0] {
    PH_START, PH_TEXT, PH_NAME, PH_VALUE, PH_FIELDS,
    PH_PAYLOAD, PH_TRAIL1, PH_TRAIL2, PH_SKIP
  } phase_e;

  // Result kinds.
  localparam logic [2:0] K_TEXT  = 3'd0;
  localparam logic [2:0] K_NAME  = 3'd1;
  localparam logic [2:0] K_VALUE = 3'd2;
  localparam logic [2:0] K_PAY   = 3'd3;
  localparam logic [2:0] K_END   = 3'd4;

  // Line classes.
  localparam logic [3:0] CL_REPLY     = 4'd0;
  localparam logic [3:0] CL_URC       = 4'd1;
  localparam logic [3:0] CL_DONE      = 4'd2;
  localparam logic [3:0] CL_ERROR     = 4'd3;
  localparam logic [3:0] CL_IGNORED   = 4'd4;
  localparam logic [3:0] CL_HEADER    = 4'd5;
  localparam logic [3:0] CL_CONTENT   = 4'd6;
  localparam logic [3:0] CL_PROMPT    = 4'd7;
  localparam logic [3:0] CL_MALFORMED = 4'd8;
  localparam logic [3:0] CL_OVERFLOW  = 4'd9;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_E0    = 8'hE0;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam logic [8*2-1:0]  S_OK  = "OK";
  localparam logic [8*5-1:0]  S_ERR = "ERROR";
  localparam logic [8*10-1:0] S_CME = "+CME ERROR";
  localparam logic [8*19-1:0] S_HDR = "+MHTTPURC: \"header\"";
  localparam logic [8*20-1:0] S_CNT = "+MHTTPURC: \"content\"";

  // Per-line control state.
  typedef struct packed {
    phase_e     phase;
    logic [4:0] pos;
    logic [3:0] pm;
    logic       pret;
    logic       pcol;
    logic [3:0] argc;
  } ctl_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [3:0]  arg;
    logic [3:0]  cls;
    logic [31:0] n0;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] n3;
    logic        last;
  } res_t;

  function automatic logic ok_at(input logic [4:0] i, input logic [7:0] b);
    logic [4:0] j;
    j = (i < 5'd2) ? i : 5'd0;
    return (i < 5'd2) && (S_OK[8*(1-int'(j)) +: 8] == b);
  endfunction

  function automatic logic err_at(input logic [4:0] i, input logic [7:0] b);
    logic [4:0] j;
    j = (i < 5'd5) ? i : 5'd0;
    return (i < 5'd5) && (S_ERR[8*(4-int'(j)) +: 8] == b);
  endfunction

  function automatic logic cme_at(input logic [4:0] i, input logic [7:0] b);
    logic [4:0] j;
    j = (i < 5'd10) ? i : 5'd0;
    return (i < 5'd10) && (S_CME[8*(9-int'(j)) +: 8] == b);
  endfunction

  function automatic logic hdr_at(input logic [4:0] i, input logic [7:0] b);
    logic [4:0] j;
    j = (i < 5'd19) ? i : 5'd0;
    return (i < 5'd19) && (S_HDR[8*(18-int'(j)) +: 8] == b);
  endfunction

  function automatic logic cnt_at(input logic [4:0] i, input logic [7:0] b);
    logic [4:0] j;
    j = (i < 5'd20) ? i : 5'd0;
    return (i < 5'd20) && (S_CNT[8*(19-int'(j)) +: 8] == b);
  endfunction

  // Advances the prefix matchers by one byte of the line.
  function automatic ctl_t consume(input ctl_t c, input logic [7:0] b);
    ctl_t o;
    o = c;
    if (c.phase == PH_TEXT) begin
      if (!ok_at(c.pos, b)) o.pm[0] = 1'b0;
      if (!err_at(c.pos, b)) o.pm[1] = 1'b0;
    end else begin
      if (c.phase == PH_NAME && !cme_at(c.pos, b)) o.pm[0] = 1'b0;
      if (!hdr_at(c.pos, b)) o.pm[2] = 1'b0;
      if (!cnt_at(c.pos, b)) o.pm[3] = 1'b0;
    end
    if (c.pos != 5'd31) o.pos = c.pos + 5'd1;
    return o;
  endfunction

endpackage

@@ rtl/arf_step.sv @@
module arf_step #(
  parameter int NW = 32
) (
  input  arf_pkg::ctl_t     ctl_i,
  input  logic [3:0][NW-1:0] nums_i,
  input  logic [NW-1:0]     prem_i,
  input  logic              binary_mode_i,
  input  logic              mode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              awaiting_reply_i,
  output arf_pkg::ctl_t     ctl_o,
  output logic [3:0][NW-1:0] nums_o,
  output logic [NW-1:0]     prem_o,
  output arf_pkg::res_t     res0_o,
  output arf_pkg::res_t     res1_o,
  output logic [1:0]        nres_o
);

  localparam logic [NW+3:0] MaxVal = {4'd0, {NW{1'b1}}};

  typedef struct packed {
    arf_pkg::ctl_t     c;
    logic [3:0][NW-1:0] n;
    logic [NW-1:0]     prem;
  } w_t;

  // Decimal accumulate with saturation; shifts and adds stand in for the x10.
  function automatic logic [NW-1:0] sat_digit(input logic [NW-1:0] v,
                                              input logic [7:0] b);
    logic [NW+3:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} +
        {{(NW){1'b0}}, 4'(b - arf_pkg::CH_D0)};
    return (t > MaxVal) ? {NW{1'b1}} : t[NW-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= arf_pkg::CH_D0) && (b <= arf_pkg::CH_D9);
  endfunction

  function automatic arf_pkg::res_t mk(input logic [2:0] k, input logic [7:0] d,
                                        input logic [3:0] a, input logic [3:0] cl);
    arf_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.data = d;
    r.arg  = a;
    r.cls  = cl;
    return r;
  endfunction

  function automatic w_t clear_line(input w_t w);
    w_t o;
    o = w;
    o.c.pos  = '0;
    o.c.pm   = 4'hF;
    o.c.pret = 1'b0;
    o.c.pcol = 1'b0;
    o.c.argc = '0;
    o.n      = '0;
    o.prem   = '0;
    return o;
  endfunction

  // One content byte of a text, name or value line.
  function automatic void content(input w_t w, input logic [7:0] b, input logic bm,
                                  output w_t wo, output arf_pkg::res_t r,
                                  output logic e);
    wo = w;
    r  = '0;
    e  = 1'b0;
    if (w.c.phase == arf_pkg::PH_TEXT) begin
      e = 1'b1;
      r = mk(arf_pkg::K_TEXT, b, 4'd0, arf_pkg::CL_REPLY);
      wo.c = arf_pkg::consume(wo.c, b);
    end else if (w.c.phase == arf_pkg::PH_NAME) begin
      e = 1'b1;
      r = mk(arf_pkg::K_NAME, b, 4'd0, arf_pkg::CL_REPLY);
      wo.c = arf_pkg::consume(wo.c, b);
    end else begin
      if (b == arf_pkg::CH_COMMA) begin
        if (wo.c.argc != 4'd15) wo.c.argc = wo.c.argc + 4'd1;
      end else begin
        e = 1'b1;
        r = mk(arf_pkg::K_VALUE, b, wo.c.argc, arf_pkg::CL_REPLY);
        if (wo.c.pm[0] && wo.c.argc == 4'd0) begin
          if (is_digit(b) && wo.n[2] == '0) begin
            if (wo.n[1] < NW'(10)) wo.n[1] = wo.n[1] + NW'(1);
            wo.n[0] = sat_digit(wo.n[0], b);
          end else begin
            wo.n[2] = NW'(1);
          end
        end
      end
      wo.c = arf_pkg::consume(wo.c, b);
      if (bm && ((wo.c.pos == 5'd19 && wo.c.pm[2]) ||
                 (wo.c.pos == 5'd20 && wo.c.pm[3]))) begin
        wo.c.phase = arf_pkg::PH_FIELDS;
        wo.c.argc  = '0;
        wo.c.pos   = '0;
        wo.n       = '0;
      end
    end
  endfunction

  // Line end: classify, clear and return to line start.
  function automatic void finish_line(input w_t w, output w_t wo,
                                      output arf_pkg::res_t r);
    logic [3:0]    cl;
    logic [NW-1:0] code;
    code = '0;
    if (w.c.phase == arf_pkg::PH_TEXT) begin
      if (w.c.pos == 5'd0) cl = arf_pkg::CL_IGNORED;
      else if (w.c.pm[0] && w.c.pos == 5'd2) cl = arf_pkg::CL_DONE;
      else if (w.c.pm[1] && w.c.pos == 5'd5) cl = arf_pkg::CL_ERROR;
      else if (w.c.pm[3]) cl = arf_pkg::CL_IGNORED;
      else cl = arf_pkg::CL_REPLY;
    end else if (w.c.phase == arf_pkg::PH_NAME) begin
      if (w.c.pos <= 5'd1) cl = arf_pkg::CL_IGNORED;
      else if (w.c.pm[0] && w.c.pos == 5'd10) cl = arf_pkg::CL_ERROR;
      else cl = arf_pkg::CL_URC;
    end else begin
      if (w.c.pm[1]) cl = arf_pkg::CL_IGNORED;
      else if (w.c.pm[0]) begin
        cl = arf_pkg::CL_ERROR;
        if (w.n[2] == '0 && w.n[1] >= NW'(1) && w.n[1] <= NW'(9)) code = w.n[0];
      end else cl = arf_pkg::CL_URC;
    end
    r = mk(arf_pkg::K_END, 8'd0, 4'd0, cl);
    r.n0 = 32'(code);
    wo = clear_line(w);
    wo.c.phase = arf_pkg::PH_START;
  endfunction

  // Byte of a text, name or value line, with CR and colon lookahead.
  function automatic void line_byte(input w_t w, input logic [7:0] b, input logic bm,
                                    output w_t wo,
                                    output arf_pkg::res_t r0, output logic e0,
                                    output arf_pkg::res_t r1, output logic e1);
    logic done;
    logic cme;
    logic empty;
    logic [3:0] m;
    wo = w;
    r0 = '0;
    r1 = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    done = 1'b0;
    if (wo.c.pret) begin
      wo.c.pret = 1'b0;
      if (b == arf_pkg::CH_LF) begin
        finish_line(wo, wo, r0);
        e0 = 1'b1;
        done = 1'b1;
      end else begin
        content(wo, arf_pkg::CH_CR, bm, wo, r0, e0);
      end
    end
    if (!done && wo.c.phase == arf_pkg::PH_NAME && wo.c.pcol) begin
      wo.c.pcol = 1'b0;
      if (b == arf_pkg::CH_SPACE) begin
        cme   = wo.c.pm[0] && wo.c.pos == 5'd10;
        empty = wo.c.pos == 5'd1;
        wo.c  = arf_pkg::consume(wo.c, arf_pkg::CH_COLON);
        wo.c  = arf_pkg::consume(wo.c, arf_pkg::CH_SPACE);
        wo.c.phase = arf_pkg::PH_VALUE;
        wo.c.argc  = '0;
        m = wo.c.pm & 4'hC;
        m[0] = cme;
        m[1] = empty;
        wo.c.pm = m;
        done = 1'b1;
      end else begin
        content(wo, arf_pkg::CH_COLON, bm, wo, r0, e0);
      end
    end
    if (!done) begin
      if (b == arf_pkg::CH_CR) wo.c.pret = 1'b1;
      else if (wo.c.phase == arf_pkg::PH_NAME && b == arf_pkg::CH_COLON) wo.c.pcol = 1'b1;
      else content(wo, b, bm, wo, r1, e1);
    end
  endfunction

  w_t            w;
  arf_pkg::res_t r0;
  arf_pkg::res_t r1;
  logic          e0;
  logic          e1;
  logic          hdr;
  logic [3:0]    nf;
  logic [1:0]    fi;

  // Next state and results for one accepted item.
  always_comb begin
    w.c    = ctl_i;
    w.n    = nums_i;
    w.prem = prem_i;
    r0 = '0;
    r1 = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    hdr = w.c.pm[2];
    nf  = hdr ? 4'd3 : 4'd4;
    fi  = w.c.argc[1:0] - 2'd1;
    if (mode_i) begin
      w = clear_line(w);
      w.c.phase = arf_pkg::PH_START;
      r0 = mk(arf_pkg::K_END, 8'd0, 4'd0, arf_pkg::CL_OVERFLOW);
      e0 = 1'b1;
    end else begin
      unique case (w.c.phase)
        arf_pkg::PH_START: begin
          if (awaiting_reply_i && rx_byte_i == arf_pkg::CH_GT) begin
            r0 = mk(arf_pkg::K_END, 8'd0, 4'd0, arf_pkg::CL_PROMPT);
            e0 = 1'b1;
          end else begin
            w = clear_line(w);
            if (rx_byte_i == arf_pkg::CH_PLUS) begin
              w.c.phase = arf_pkg::PH_NAME;
              w.c = arf_pkg::consume(w.c, rx_byte_i);
            end else begin
              w.c.phase = arf_pkg::PH_TEXT;
              if (rx_byte_i != arf_pkg::CH_E0) w.c.pm[3] = 1'b0;
              line_byte(w, rx_byte_i, binary_mode_i, w, r0, e0, r1, e1);
            end
          end
        end
        arf_pkg::PH_TEXT, arf_pkg::PH_NAME, arf_pkg::PH_VALUE: begin
          line_byte(w, rx_byte_i, binary_mode_i, w, r0, e0, r1, e1);
        end
        arf_pkg::PH_FIELDS: begin
          if (w.c.argc == 4'd0) begin
            if (rx_byte_i == arf_pkg::CH_COMMA) begin
              w.c.argc = 4'd1;
              w.c.pos  = '0;
            end else begin
              w.c.phase = arf_pkg::PH_SKIP;
              w.c.pret  = rx_byte_i == arf_pkg::CH_CR;
            end
          end else if (is_digit(rx_byte_i)) begin
            w.n[fi] = sat_digit(w.n[fi], rx_byte_i);
            if (w.c.pos != 5'd31) w.c.pos = w.c.pos + 5'd1;
            r0 = mk(arf_pkg::K_VALUE, rx_byte_i, w.c.argc, arf_pkg::CL_REPLY);
            e0 = 1'b1;
          end else if (w.c.pos == 5'd0 ||
                       (w.c.argc < nf && rx_byte_i != arf_pkg::CH_COMMA) ||
                       (w.c.argc >= nf && hdr && rx_byte_i != arf_pkg::CH_COMMA) ||
                       (w.c.argc >= nf && !hdr && w.n[3] != '0 &&
                        rx_byte_i != arf_pkg::CH_COMMA)) begin
            // Missing digit or separator.
            w.c.phase = arf_pkg::PH_SKIP;
            w.c.pret  = rx_byte_i == arf_pkg::CH_CR;
          end else if (w.c.argc < nf) begin
            w.c.argc = w.c.argc + 4'd1;
            w.c.pos  = '0;
          end else if (hdr) begin
            w.c.argc  = 4'd4;
            w.prem    = w.n[2];
            w.c.phase = (w.n[2] != '0) ? arf_pkg::PH_PAYLOAD : arf_pkg::PH_TRAIL1;
          end else if (w.n[3] == '0) begin
            w.c.phase = arf_pkg::PH_TRAIL2;
          end else begin
            w.c.argc  = 4'd5;
            w.prem    = w.n[3];
            w.c.phase = arf_pkg::PH_PAYLOAD;
          end
        end
        arf_pkg::PH_PAYLOAD: begin
          r0 = mk(arf_pkg::K_PAY, rx_byte_i, w.c.argc, arf_pkg::CL_REPLY);
          e0 = 1'b1;
          w.prem = w.prem - NW'(1);
          if (w.prem == '0) w.c.phase = arf_pkg::PH_TRAIL1;
        end
        arf_pkg::PH_TRAIL1: begin
          w.c.phase = arf_pkg::PH_TRAIL2;
        end
        arf_pkg::PH_TRAIL2: begin
          r0 = mk(arf_pkg::K_END, 8'd0, 4'd0,
                  w.c.pm[2] ? arf_pkg::CL_HEADER : arf_pkg::CL_CONTENT);
          r0.n0 = 32'(w.n[0]);
          r0.n1 = 32'(w.n[1]);
          r0.n2 = 32'(w.n[2]);
          r0.n3 = 32'(w.n[3]);
          e0 = 1'b1;
          w = clear_line(w);
          w.c.phase = arf_pkg::PH_START;
        end
        arf_pkg::PH_SKIP: begin
          if (rx_byte_i == arf_pkg::CH_LF && w.c.pret) begin
            r0 = mk(arf_pkg::K_END, 8'd0, 4'd0, arf_pkg::CL_MALFORMED);
            e0 = 1'b1;
            w = clear_line(w);
            w.c.phase = arf_pkg::PH_START;
          end else begin
            w.c.pret = rx_byte_i == arf_pkg::CH_CR;
          end
        end
        default: begin
          w = clear_line(w);
          w.c.phase = arf_pkg::PH_START;
        end
      endcase
    end
  end

  // Pack the results to the front and mark the last one.
  always_comb begin
    ctl_o  = w.c;
    nums_o = w.n;
    prem_o = w.prem;
    res0_o = e0 ? r0 : r1;
    res1_o = r1;
    nres_o = {1'b0, e0} + {1'b0, e1};
    res0_o.last = !(e0 && e1);
    res1_o.last = 1'b1;
  end

endmodule

@@ rtl/at_reply_line_framer.sv @@
// AT reply line framer: takes one modem reply byte (or an overflow event) per
// transfer and produces tagged byte results and one record-end result per line.
// An input transfer is taken in the cycle it is offered as long as the result
// queue (four entries) has room for two results; each input yields zero to two
// results, and results leave at one per cycle while out_stall_i is low, so the
// sustained rate is one input per cycle while inputs average at most one result
// each. Results are registered in the queue and reach the output in the cycle
// after their input at earliest, later if older results wait. The user must write
// binary_mode via cfg_we_i/cfg_wdata_i only while the block is idle (unenforced).
module at_reply_line_framer #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        awaiting_reply_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_o,
  output logic [3:0]  arg_index_o,
  output logic [3:0]  line_class_o,
  output logic [31:0] first_number_o,
  output logic [31:0] second_number_o,
  output logic [31:0] third_number_o,
  output logic [31:0] fourth_number_o,
  output logic        last_o
);

`include "at_reply_line_framer_macros.svh"

  logic                         binary_mode_q;
  arf_pkg::ctl_t                ctl_q;
  arf_pkg::ctl_t                ctl_d;
  logic [3:0][NUMBER_WIDTH-1:0] nums_q;
  logic [3:0][NUMBER_WIDTH-1:0] nums_d;
  logic [NUMBER_WIDTH-1:0]      prem_q;
  logic [NUMBER_WIDTH-1:0]      prem_d;
  arf_pkg::res_t                res0;
  arf_pkg::res_t                res1;
  logic [1:0]                   nres;
  arf_pkg::res_t                fifo_q [4];
  logic [1:0]                   wp_q;
  logic [1:0]                   rp_q;
  logic [2:0]                   cnt_q;
  logic                         in_acc;
  logic                         out_acc;
  arf_pkg::res_t                head;

  arf_step #(
    .NW(NUMBER_WIDTH)
  ) u_step (
    .ctl_i           (ctl_q),
    .nums_i          (nums_q),
    .prem_i          (prem_q),
    .binary_mode_i   (binary_mode_q),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .awaiting_reply_i(awaiting_reply_i),
    .ctl_o           (ctl_d),
    .nums_o          (nums_d),
    .prem_o          (prem_d),
    .res0_o          (res0),
    .res1_o          (res1),
    .nres_o          (nres)
  );

  // Handshakes.
  assign in_stall_o  = cnt_q > 3'd2;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      binary_mode_q <= cfg_wdata_i;
    end
  end

  // Line state, updated on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase <= arf_pkg::PH_START;
      ctl_q.pos   <= '0;
      ctl_q.pm    <= 4'hF;
      ctl_q.pret  <= 1'b0;
      ctl_q.pcol  <= 1'b0;
      ctl_q.argc  <= '0;
      nums_q      <= '0;
      prem_q      <= '0;
    end else if (in_acc) begin
      ctl_q  <= ctl_d;
      nums_q <= nums_d;
      prem_q <= prem_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (in_acc && nres != 2'd0) begin
      fifo_q[wp_q] <= res0;
    end
    if (in_acc && nres == 2'd2) begin
      fifo_q[wp_q + 2'd1] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) wp_q <= wp_q + nres;
      if (out_acc) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + (in_acc ? {1'b0, nres} : 3'd0) - {2'd0, out_acc};
    end
  end

  // Head of the queue drives the result ports.
  assign head            = fifo_q[rp_q];
  assign kind_o          = head.kind;
  assign data_o          = head.data;
  assign arg_index_o     = head.arg;
  assign line_class_o    = head.cls;
  assign first_number_o  = head.n0;
  assign second_number_o = head.n1;
  assign third_number_o  = head.n2;
  assign fourth_number_o = head.n3;
  assign last_o          = head.last;

  // The queue never takes an input without room for two results.
  `ARF_ASSERT_IMP(a_room, in_acc, cnt_q <= 3'd2)
  // An overflow event yields exactly one result.
  `ARF_ASSERT_IMP(a_ovf_one, in_acc && mode_i, nres == 2'd1)
  // After an overflow event the parser is back at line start.
  `ARF_ASSERT_NXT(a_ovf_start, in_acc && mode_i, ctl_q.phase == arf_pkg::PH_START)

endmodule

@@ dv/tb_at_reply_line_framer.sv @@
`timescale 1ns / 1ps

module tb_at_reply_line_framer;

  typedef struct packed {
    logic       ovf;
    logic [7:0] rx;
    logic       await_r;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        awaiting_reply_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  data_o;
  logic [3:0]  arg_index_o;
  logic [3:0]  line_class_o;
  logic [31:0] first_number_o;
  logic [31:0] second_number_o;
  logic [31:0] third_number_o;
  logic [31:0] fourth_number_o;
  logic        last_o;

  at_reply_line_framer #(.NUMBER_WIDTH(32)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .mode_i, .rx_byte_i, .awaiting_reply_i, .out_valid_o, .out_stall_i,
    .kind_o, .data_o, .arg_index_o, .line_class_o, .first_number_o,
    .second_number_o, .third_number_o, .fourth_number_o, .last_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  rx_item_t        tx_q[$];
  arf_pkg::res_t   frame_q[$];
  arf_pkg::res_t   step_res[$];
  int              errors = 0;
  int              pushed = 0;
  int              accepted = 0;

  // Shadow copy of the framer state.
  logic             bin_mode = 1'b0;
  arf_pkg::phase_e  ph = arf_pkg::PH_START;
  logic [4:0]       lpos = '0;
  logic [3:0]       pm = 4'hF;
  logic             pret = 1'b0;
  logic             pcol = 1'b0;
  logic [3:0]       argc = '0;
  logic [31:0]      nf[4] = '{default: '0};
  logic [31:0]      premain = '0;

  function automatic bit lit_at(string s, int i, logic [7:0] b);
    return i < s.len() && s[i] == b;
  endfunction

  function automatic logic [31:0] sat_dig(logic [31:0] v, logic [7:0] b);
    logic [63:0] t;
    t = 64'(v) * 64'd10 + 64'(b - 8'h30);
    return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= arf_pkg::CH_D0 && b <= arf_pkg::CH_D9;
  endfunction

  task automatic emit(logic [2:0] k, logic [7:0] d, logic [3:0] a, logic [3:0] c,
                      logic [31:0] n0, logic [31:0] n1, logic [31:0] n2, logic [31:0] n3);
    arf_pkg::res_t r;
    r = '{kind: k, data: d, arg: a, cls: c, n0: n0, n1: n1, n2: n2, n3: n3, last: 1'b0};
    if (step_res.size() < 2) step_res.insert(step_res.size(), r);
  endtask

  task automatic clear_line();
    lpos = '0; pm = 4'hF; pret = 1'b0; pcol = 1'b0; argc = '0;
    nf = '{default: '0}; premain = '0;
  endtask

  // Advances the prefix matchers by one line byte.
  task automatic match_byte(logic [7:0] b);
    logic [3:0] m;
    m = pm;
    if (ph == arf_pkg::PH_TEXT) begin
      if (!lit_at("OK", int'(lpos), b)) m[0] = 1'b0;
      if (!lit_at("ERROR", int'(lpos), b)) m[1] = 1'b0;
    end else begin
      if (ph == arf_pkg::PH_NAME && !lit_at("+CME ERROR", int'(lpos), b)) m[0] = 1'b0;
      if (!lit_at("+MHTTPURC: \"header\"", int'(lpos), b)) m[2] = 1'b0;
      if (!lit_at("+MHTTPURC: \"content\"", int'(lpos), b)) m[3] = 1'b0;
    end
    pm = m;
    if (lpos < 5'd31) lpos++;
  endtask

  task automatic start_fields();
    ph = arf_pkg::PH_FIELDS; argc = '0; lpos = '0; nf = '{default: '0};
  endtask

  task automatic line_content(logic [7:0] b);
    if (ph == arf_pkg::PH_TEXT) begin
      emit(arf_pkg::K_TEXT, b, '0, '0, '0, '0, '0, '0);
      match_byte(b);
    end else if (ph == arf_pkg::PH_NAME) begin
      emit(arf_pkg::K_NAME, b, '0, '0, '0, '0, '0, '0);
      match_byte(b);
    end else begin
      if (b == arf_pkg::CH_COMMA) begin
        if (argc < 4'd15) argc++;
      end else begin
        emit(arf_pkg::K_VALUE, b, argc, '0, '0, '0, '0, '0);
        if (pm[0] && argc == 4'd0) begin
          if (is_digit(b) && nf[2] == 32'd0) begin
            if (nf[1] < 32'd10) nf[1]++;
            nf[0] = sat_dig(nf[0], b);
          end else begin
            nf[2] = 32'd1;
          end
        end
      end
      match_byte(b);
      if (bin_mode) begin
        if (lpos == 5'd19 && pm[2]) start_fields();
        else if (lpos == 5'd20 && pm[3]) start_fields();
      end
    end
  endtask

  // Closes a CR LF ended line with its class.
  task automatic close_line();
    logic [3:0]  cls;
    logic [31:0] code;
    code = '0;
    if (ph == arf_pkg::PH_TEXT) begin
      if (lpos == 5'd0) cls = arf_pkg::CL_IGNORED;
      else if (pm[0] && lpos == 5'd2) cls = arf_pkg::CL_DONE;
      else if (pm[1] && lpos == 5'd5) cls = arf_pkg::CL_ERROR;
      else if (pm[3]) cls = arf_pkg::CL_IGNORED;
      else cls = arf_pkg::CL_REPLY;
    end else if (ph == arf_pkg::PH_NAME) begin
      if (lpos <= 5'd1) cls = arf_pkg::CL_IGNORED;
      else if (pm[0] && lpos == 5'd10) cls = arf_pkg::CL_ERROR;
      else cls = arf_pkg::CL_URC;
    end else begin
      if (pm[1]) cls = arf_pkg::CL_IGNORED;
      else if (pm[0]) begin
        cls = arf_pkg::CL_ERROR;
        if (nf[2] == 32'd0 && nf[1] >= 32'd1 && nf[1] <= 32'd9) code = nf[0];
      end else cls = arf_pkg::CL_URC;
    end
    emit(arf_pkg::K_END, '0, '0, cls, code, '0, '0, '0);
    clear_line();
    ph = arf_pkg::PH_START;
  endtask

  task automatic text_byte(logic [7:0] b);
    bit         cme;
    bit         empty;
    logic [3:0] m;
    if (pret) begin
      pret = 1'b0;
      if (b == arf_pkg::CH_LF) begin
        close_line();
        return;
      end
      line_content(arf_pkg::CH_CR);
    end
    if (ph == arf_pkg::PH_NAME && pcol) begin
      pcol = 1'b0;
      if (b == arf_pkg::CH_SPACE) begin
        cme = pm[0] && lpos == 5'd10;
        empty = lpos == 5'd1;
        match_byte(arf_pkg::CH_COLON);
        match_byte(arf_pkg::CH_SPACE);
        ph = arf_pkg::PH_VALUE;
        argc = '0;
        m = pm & 4'hC;
        if (cme) m[0] = 1'b1;
        if (empty) m[1] = 1'b1;
        pm = m;
        return;
      end
      line_content(arf_pkg::CH_COLON);
    end
    if (b == arf_pkg::CH_CR) begin
      pret = 1'b1;
      return;
    end
    if (ph == arf_pkg::PH_NAME && b == arf_pkg::CH_COLON) begin
      pcol = 1'b1;
      return;
    end
    line_content(b);
  endtask

  task automatic go_skip(logic [7:0] b);
    ph = arf_pkg::PH_SKIP;
    pret = (b == arf_pkg::CH_CR);
  endtask

  task automatic start_payload(logic [31:0] n);
    premain = n;
    ph = (n != 32'd0) ? arf_pkg::PH_PAYLOAD : arf_pkg::PH_TRAIL1;
  endtask

  // Decimal fields that follow an HTTP record prefix.
  task automatic field_step(logic [7:0] b);
    bit hdr;
    int nfl;
    int idx;
    hdr = pm[2];
    nfl = hdr ? 3 : 4;
    idx = int'(argc);
    if (idx == 0) begin
      if (b == arf_pkg::CH_COMMA) begin
        argc = 4'd1; lpos = '0;
      end else go_skip(b);
      return;
    end
    if (is_digit(b)) begin
      nf[(idx - 1) & 3] = sat_dig(nf[(idx - 1) & 3], b);
      if (lpos < 5'd31) lpos++;
      emit(arf_pkg::K_VALUE, b, idx[3:0], '0, '0, '0, '0, '0);
      return;
    end
    if (lpos == 5'd0) begin
      go_skip(b);
      return;
    end
    if (idx < nfl) begin
      if (b == arf_pkg::CH_COMMA) begin
        argc++; lpos = '0;
      end else go_skip(b);
      return;
    end
    if (hdr) begin
      if (b != arf_pkg::CH_COMMA) begin
        go_skip(b);
        return;
      end
      argc = 4'd4;
      start_payload(nf[2]);
    end else if (nf[3] == 32'd0) begin
      ph = arf_pkg::PH_TRAIL2;
    end else if (b == arf_pkg::CH_COMMA) begin
      argc = 4'd5;
      start_payload(nf[3]);
    end else begin
      go_skip(b);
    end
  endtask

  // Predicts the results of one accepted transfer and queues them.
  task automatic predict_frame(rx_item_t it);
    step_res.delete();
    if (it.ovf) begin
      ph = arf_pkg::PH_START;
      clear_line();
      emit(arf_pkg::K_END, '0, '0, arf_pkg::CL_OVERFLOW, '0, '0, '0, '0);
    end else begin
      case (ph)
        arf_pkg::PH_START: begin
          if (it.await_r && it.rx == arf_pkg::CH_GT) begin
            emit(arf_pkg::K_END, '0, '0, arf_pkg::CL_PROMPT, '0, '0, '0, '0);
          end else begin
            clear_line();
            if (it.rx == arf_pkg::CH_PLUS) begin
              ph = arf_pkg::PH_NAME;
              match_byte(it.rx);
            end else begin
              ph = arf_pkg::PH_TEXT;
              if (it.rx != arf_pkg::CH_E0) pm[3] = 1'b0;
              text_byte(it.rx);
            end
          end
        end
        arf_pkg::PH_TEXT, arf_pkg::PH_NAME, arf_pkg::PH_VALUE: text_byte(it.rx);
        arf_pkg::PH_FIELDS: field_step(it.rx);
        arf_pkg::PH_PAYLOAD: begin
          emit(arf_pkg::K_PAY, it.rx, argc, '0, '0, '0, '0, '0);
          premain--;
          if (premain == 32'd0) ph = arf_pkg::PH_TRAIL1;
        end
        arf_pkg::PH_TRAIL1: ph = arf_pkg::PH_TRAIL2;
        arf_pkg::PH_TRAIL2: begin
          emit(arf_pkg::K_END, '0, '0, pm[2] ? arf_pkg::CL_HEADER : arf_pkg::CL_CONTENT,
               nf[0], nf[1], nf[2], nf[3]);
          clear_line();
          ph = arf_pkg::PH_START;
        end
        arf_pkg::PH_SKIP: begin
          if (it.rx == arf_pkg::CH_LF && pret) begin
            emit(arf_pkg::K_END, '0, '0, arf_pkg::CL_MALFORMED, '0, '0, '0, '0);
            clear_line();
            ph = arf_pkg::PH_START;
          end else begin
            pret = (it.rx == arf_pkg::CH_CR);
          end
        end
        default: begin
          ph = arf_pkg::PH_START;
          clear_line();
        end
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) frame_q.insert(frame_q.size(), step_res[i]);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    rx_item_t nxt;
    rx_item_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen.ovf = mode_i;
        seen.rx = rx_byte_i;
        seen.await_r = awaiting_reply_i;
        predict_frame(seen);
        accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tx_q.size() > 0) begin
          nxt = tx_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= nxt.ovf;
          rx_byte_i <= nxt.rx;
          awaiting_reply_i <= nxt.await_r;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that changes every window, plus one long hold-off.
  int  stall_style = 0;
  int  win_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (!hold_done && accepted >= 180) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (win_left == 0) begin
      win_left = $urandom_range(20, 80);
      stall_style = $urandom_range(0, 3);
    end else win_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 30);
        2: out_stall_i <= ~out_stall_i;
        default: out_stall_i <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (at %0t)", what, got, want, $realtime);
  endtask

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    arf_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        report_err("unexpected result, kind", 32'(kind_o), '0);
      end else begin
        want = frame_q.pop_front();
        if (kind_o != want.kind) report_err("kind", 32'(kind_o), 32'(want.kind));
        if (data_o != want.data) report_err("data", 32'(data_o), 32'(want.data));
        if (arg_index_o != want.arg)
          report_err("arg_index", 32'(arg_index_o), 32'(want.arg));
        if (line_class_o != want.cls)
          report_err("line_class", 32'(line_class_o), 32'(want.cls));
        if (first_number_o != want.n0) report_err("first_number", first_number_o, want.n0);
        if (second_number_o != want.n1) report_err("second_number", second_number_o, want.n1);
        if (third_number_o != want.n2) report_err("third_number", third_number_o, want.n2);
        if (fourth_number_o != want.n3) report_err("fourth_number", fourth_number_o, want.n3);
        if (last_o != want.last) report_err("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  task automatic push_raw(logic ovf, logic [7:0] b, logic aw);
    rx_item_t it;
    it.ovf = ovf;
    it.rx = b;
    it.await_r = aw;
    tx_q.insert(tx_q.size(), it);
    pushed++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_raw(1'b0, s[i], 1'($urandom_range(0, 1)));
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(8'h30 + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_text(int n);
    string s;
    logic [7:0] c;
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: c = arf_pkg::CH_COMMA;
        1: c = arf_pkg::CH_COLON;
        2: c = arf_pkg::CH_SPACE;
        3: c = 8'(8'h30 + $urandom_range(0, 9));
        default: c = 8'(8'h41 + $urandom_range(0, 25));
      endcase
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // Binary record of either kind; sometimes with a broken separator.
  task automatic push_record(bit hdr);
    int len;
    int sum;
    string s;
    len = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    sum = $urandom_range(0, 99);
    if (hdr) s = $sformatf("+MHTTPURC: \"header\",%0d,%0d,%0d", $urandom_range(0, 9),
                           $urandom_range(100, 599), len);
    else s = $sformatf("+MHTTPURC: \"content\",%0d,%0d,%0d,%0d", $urandom_range(0, 9),
                       sum + len, sum, len);
    if ($urandom_range(0, 9) == 0) s = {s, ";"};
    else if (hdr || len != 0) s = {s, ","};
    push_str(s);
    for (int i = 0; i < len; i++)
      push_raw(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_str("\r\n");
  endtask

  // One well-formed line of random type, or some noise.
  task automatic push_line();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0: push_str("OK\r\n");
      1: push_str("ERROR\r\n");
      2: push_str({"+CME ERROR: ", rand_digits($urandom_range(0, 11)),
                   ($urandom_range(0, 3) == 0) ? rand_text(3) : "", "\r\n"});
      3: push_str({"+", rand_text($urandom_range(0, 6)), ": ",
                   rand_text($urandom_range(0, 10)), "\r\n"});
      4: push_str({rand_text($urandom_range(1, 10)), "\r\n"});
      5: push_raw(1'b0, arf_pkg::CH_GT, 1'b1);
      6: begin
        push_raw(1'b0, arf_pkg::CH_E0, 1'($urandom_range(0, 1)));
        push_str({rand_text($urandom_range(0, 3)), "\r\n"});
      end
      7, 8: push_record(1'b1);
      9, 10: push_record(1'b0);
      default: begin
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0)
            b = $urandom_range(0, 1) ? arf_pkg::CH_CR : arf_pkg::CH_LF;
          push_raw($urandom_range(0, 15) == 0, b, 1'($urandom_range(0, 1)));
        end
        push_str("\r\n");
      end
    endcase
  endtask

  task automatic wait_drained();
    wait (tx_q.size() == 0 && !in_valid_i && frame_q.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    bin_mode = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = pushed + n;
    while (pushed < stop_at) push_line();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);
    // Directed lines: exact matches, near misses, lone CR, colon and empty cases.
    push_str("OK\r\nOKX\r\nERROR\r\n+CME ERROR: 42\r\nA\rB\r\n+Q:x: 1,,2\r\n\r\n+: a\r\n");
    push_raw(1'b0, arf_pkg::CH_GT, 1'b1);
    push_raw(1'b0, arf_pkg::CH_GT, 1'b0);
    push_raw(1'b1, 8'hFF, 1'b0);
    push_raw(1'b0, arf_pkg::CH_E0, 1'b0);
    push_str("\r\n");
    run_random(60);
    write_mode(1'b1);
    push_str("+MHTTPURC: \"header\",99999999999,200,2,\r\n\r\n");
    push_str("+MHTTPURC: \"content\",1,0,0,0\r\n");
    push_str("+MHTTPURC: \"header\",,1\r\n");
    run_random(80);
    write_mode(1'b0);
    run_random(30);
    write_mode(1'b1);
    run_random(50);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
